// ===== hdl/tbpd_pkg.sv =====
// Shared codes, reset values and controller/datapath interface types for the pulse core.
package tbpd_pkg;

	// Ring depth default
	localparam int RECENT_DEPTH_DEF = 16;

	// Field widths
	localparam int SEQ_W  = 32;
	localparam int BTN_W  = 32;
	localparam int MS_W   = 16;
	localparam int CODE_W = 3;
	localparam int OP_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Opcodes
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_PULSE   = 2'd1;
	localparam logic [OP_W-1:0] OP_STATUS  = 2'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

	// Status codes
	localparam logic [CODE_W-1:0] ST_OK          = 3'd0;
	localparam logic [CODE_W-1:0] ST_INVALID     = 3'd1;
	localparam logic [CODE_W-1:0] ST_BUSY        = 3'd2;
	localparam logic [CODE_W-1:0] ST_LEGACY      = 3'd3;
	localparam logic [CODE_W-1:0] ST_ENABLE_FAIL = 3'd4;

	// Pulse state codes
	localparam logic [CODE_W-1:0] PS_IDLE      = 3'd0;
	localparam logic [CODE_W-1:0] PS_ACCEPTED  = 3'd1;
	localparam logic [CODE_W-1:0] PS_PROGRESS  = 3'd2;
	localparam logic [CODE_W-1:0] PS_COMPLETED = 3'd3;
	localparam logic [CODE_W-1:0] PS_ALREADY   = 3'd4;
	localparam logic [CODE_W-1:0] PS_ABORTED   = 3'd5;
	localparam logic [CODE_W-1:0] PS_NOT_FOUND = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETTLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL    = 2'd3;

	// Configuration reset values
	localparam logic [MS_W-1:0]  MIN_HOLD_RST   = 16'd20;
	localparam logic [MS_W-1:0]  MAX_HOLD_RST   = 16'd2000;
	localparam logic [MS_W-1:0]  MAX_SETTLE_RST = 16'd2000;
	localparam logic [BTN_W-1:0] NEUTRAL_RST    = 32'd4095;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic service;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_tick;
		logic need_scan;
		logic scan_done;
	} dp_stat_t;

endpackage

// ===== hdl/tbpd_ring.sv =====
// Ring of recent terminal pulse states: one write port, one-entry-per-cycle lookup scan while scan_step is high.
module tbpd_ring #(
	parameter int DEPTH = tbpd_pkg::RECENT_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [tbpd_pkg::SEQ_W-1:0]  wr_seq,
	input  logic [tbpd_pkg::CODE_W-1:0] wr_res,
	input  logic                        scan_clr,
	input  logic                        scan_step,
	input  logic [tbpd_pkg::SEQ_W-1:0]  key,
	output logic                        hit,
	output logic [tbpd_pkg::CODE_W-1:0] hit_res,
	output logic                        scan_done
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [tbpd_pkg::SEQ_W-1:0]  id_mem  [DEPTH];
	logic [tbpd_pkg::CODE_W-1:0] res_mem [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [IDX_W-1:0]            slot_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [IDX_W-1:0]            rd_addr;
	logic                        rd_en;
	logic [tbpd_pkg::SEQ_W-1:0]  rd_id_s1;
	logic [tbpd_pkg::CODE_W-1:0] rd_res_s1;
	logic                        rd_vld_s1;
	logic                        rd_live_s1;
	logic                        rd_last_s1;
	logic                        hit_q;
	logic [tbpd_pkg::CODE_W-1:0] hit_res_q;

	assign rd_addr = cnt_q[IDX_W-1:0];
	assign rd_en   = scan_step && (cnt_q < CNT_W'(DEPTH));

	// Write at the next slot, read the scanned entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[slot_q]  <= wr_seq;
			res_mem[slot_q] <= wr_res;
		end
		if (rd_en) begin
			rd_id_s1  <= id_mem[rd_addr];
			rd_res_s1 <= res_mem[rd_addr];
		end
	end

	// Track valid entries and advance the write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
		end else if (wr_en) begin
			valid_q[slot_q] <= 1'b1;
			if (slot_q == IDX_W'(DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// Step the scan and keep the lowest matching entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_live_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			hit_q      <= 1'b0;
			hit_res_q  <= '0;
		end else begin
			rd_live_s1 <= rd_en;
			rd_vld_s1  <= valid_q[rd_addr];
			rd_last_s1 <= (cnt_q == CNT_W'(DEPTH - 1));
			if (scan_clr) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (scan_step) begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (rd_live_s1 && rd_vld_s1 && (rd_id_s1 == key) && !hit_q) begin
					hit_q     <= 1'b1;
					hit_res_q <= rd_res_s1;
				end
			end
		end
	end

	assign hit       = hit_q;
	assign hit_res   = hit_res_q;
	assign scan_done = rd_live_s1 && rd_last_s1;

endmodule

// ===== hdl/tbpd_datapath.sv =====
// Datapath: configuration, pulse state, service and request decisions, result registers.
module tbpd_datapath #(
	parameter int RECENT_DEPTH = tbpd_pkg::RECENT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tbpd_pkg::ctl_cmd_t              cmd,
	output tbpd_pkg::dp_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [tbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tbpd_pkg::OP_W-1:0]       opcode,
	input  logic [tbpd_pkg::SEQ_W-1:0]      sequence_id,
	input  logic [tbpd_pkg::BTN_W-1:0]      buttons,
	input  logic [tbpd_pkg::MS_W-1:0]       hold_ms,
	input  logic [tbpd_pkg::MS_W-1:0]       settle_ms,
	input  logic                            legacy_on,
	input  logic                            enable_failed,
	output logic [tbpd_pkg::CODE_W-1:0]     status_code,
	output logic [tbpd_pkg::SEQ_W-1:0]      reported_sequence,
	output logic [tbpd_pkg::CODE_W-1:0]     pulse_state,
	output logic [tbpd_pkg::BTN_W-1:0]      driven_buttons,
	output logic [tbpd_pkg::MS_W-1:0]       time_remaining,
	output logic                            hid_enabled,
	output logic                            legacy_flag,
	output logic                            pulse_busy
);

	// Configuration
	logic [tbpd_pkg::MS_W-1:0]  min_hold_q, max_hold_q, max_settle_q;
	logic [tbpd_pkg::BTN_W-1:0] neutral_q;

	// Pulse state
	logic                       active_q, settling_q, inj_q;
	logic [tbpd_pkg::SEQ_W-1:0] cur_seq_q;
	logic [tbpd_pkg::BTN_W-1:0] held_q;
	logic [tbpd_pkg::MS_W-1:0]  settle_len_q, countdown_q;

	// Captured item
	logic [tbpd_pkg::OP_W-1:0]  op_q;
	logic [tbpd_pkg::SEQ_W-1:0] seq_q;
	logic [tbpd_pkg::BTN_W-1:0] btn_q;
	logic [tbpd_pkg::MS_W-1:0]  hold_q, settle_q;
	logic                       legacy_q, enfail_q;

	// Result registers
	logic [tbpd_pkg::CODE_W-1:0] status_q, pstate_q;
	logic [tbpd_pkg::SEQ_W-1:0]  rseq_q;

	// Service step
	logic [tbpd_pkg::MS_W-1:0]   cd_tick;
	logic                        svc_active, svc_settling, svc_end;
	logic [tbpd_pkg::BTN_W-1:0]  svc_held;
	logic [tbpd_pkg::MS_W-1:0]   svc_settle_len, svc_cd;
	logic [tbpd_pkg::SEQ_W-1:0]  svc_cur;
	logic [tbpd_pkg::CODE_W-1:0] svc_st;

	// Finish step
	logic                        invalid, cur_match;
	logic                        fin_active, fin_settling, fin_inj, fin_end;
	logic [tbpd_pkg::BTN_W-1:0]  fin_held;
	logic [tbpd_pkg::MS_W-1:0]   fin_settle_len, fin_cd;
	logic [tbpd_pkg::SEQ_W-1:0]  fin_cur, fin_rseq;
	logic [tbpd_pkg::CODE_W-1:0] fin_status, fin_pstate;

	// Ring access
	logic                        ring_we, ring_hit;
	logic [tbpd_pkg::CODE_W-1:0] ring_wr_res, ring_hit_res;
	logic                        scan_done;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hold_q   <= tbpd_pkg::MIN_HOLD_RST;
			max_hold_q   <= tbpd_pkg::MAX_HOLD_RST;
			max_settle_q <= tbpd_pkg::MAX_SETTLE_RST;
			neutral_q    <= tbpd_pkg::NEUTRAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbpd_pkg::CFG_MIN_HOLD:   min_hold_q   <= cfg_data[tbpd_pkg::MS_W-1:0];
				tbpd_pkg::CFG_MAX_HOLD:   max_hold_q   <= cfg_data[tbpd_pkg::MS_W-1:0];
				tbpd_pkg::CFG_MAX_SETTLE: max_settle_q <= cfg_data[tbpd_pkg::MS_W-1:0];
				tbpd_pkg::CFG_NEUTRAL:    neutral_q    <= cfg_data;
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			seq_q    <= sequence_id;
			btn_q    <= buttons;
			hold_q   <= hold_ms;
			settle_q <= settle_ms;
			legacy_q <= legacy_on;
			enfail_q <= enable_failed;
		end
	end

	// Service the running pulse: tick, abort, phase change, completion
	always_comb begin
		cd_tick = countdown_q;
		if ((op_q == tbpd_pkg::OP_TICK) && active_q && (countdown_q != '0)) begin
			cd_tick = countdown_q - 1'b1;
		end
		svc_active     = active_q;
		svc_settling   = settling_q;
		svc_held       = held_q;
		svc_settle_len = settle_len_q;
		svc_cd         = cd_tick;
		svc_cur        = cur_seq_q;
		svc_end        = 1'b0;
		svc_st         = tbpd_pkg::PS_COMPLETED;
		if (active_q) begin
			if (legacy_q) begin
				svc_end = 1'b1;
				svc_st  = tbpd_pkg::PS_ABORTED;
			end else if (cd_tick == '0) begin
				if (settling_q || (settle_len_q == '0)) begin
					svc_end = 1'b1;
				end else begin
					svc_settling = 1'b1;
					svc_cd       = settle_len_q;
					svc_held     = neutral_q;
				end
			end
		end
		if (svc_end) begin
			svc_active     = 1'b0;
			svc_settling   = 1'b0;
			svc_held       = neutral_q;
			svc_settle_len = '0;
			svc_cd         = '0;
			svc_cur        = '0;
		end
	end

	assign invalid = (seq_q == '0) || ((btn_q & ~neutral_q) != '0) || (btn_q == neutral_q) ||
		(hold_q < min_hold_q) || (hold_q > max_hold_q) || (settle_q > max_settle_q);
	assign cur_match = active_q && (cur_seq_q == seq_q);

	// Decide the request and form the result
	always_comb begin
		fin_active     = active_q;
		fin_settling   = settling_q;
		fin_inj        = inj_q;
		fin_held       = held_q;
		fin_settle_len = settle_len_q;
		fin_cd         = countdown_q;
		fin_cur        = cur_seq_q;
		fin_end        = 1'b0;
		fin_status     = tbpd_pkg::ST_OK;
		fin_rseq       = '0;
		fin_pstate     = tbpd_pkg::PS_IDLE;
		unique case (op_q)
			tbpd_pkg::OP_PULSE: begin
				fin_rseq = seq_q;
				if (invalid) begin
					fin_status = tbpd_pkg::ST_INVALID;
					fin_pstate = tbpd_pkg::PS_ABORTED;
				end else if (cur_match) begin
					fin_pstate = tbpd_pkg::PS_PROGRESS;
				end else if (ring_hit) begin
					fin_pstate = (ring_hit_res == tbpd_pkg::PS_COMPLETED) ?
						tbpd_pkg::PS_ALREADY : ring_hit_res;
				end else if (active_q) begin
					fin_status = tbpd_pkg::ST_BUSY;
					fin_rseq   = cur_seq_q;
					fin_pstate = tbpd_pkg::PS_PROGRESS;
				end else if (legacy_q) begin
					fin_status = tbpd_pkg::ST_LEGACY;
					fin_pstate = tbpd_pkg::PS_ABORTED;
				end else if (enfail_q) begin
					fin_status = tbpd_pkg::ST_ENABLE_FAIL;
					fin_pstate = tbpd_pkg::PS_ABORTED;
				end else begin
					fin_inj        = 1'b1;
					fin_active     = 1'b1;
					fin_settling   = 1'b0;
					fin_cur        = seq_q;
					fin_held       = btn_q;
					fin_settle_len = settle_q;
					fin_cd         = hold_q;
					fin_pstate     = tbpd_pkg::PS_ACCEPTED;
				end
			end
			tbpd_pkg::OP_STATUS: begin
				fin_rseq = seq_q;
				if (seq_q == '0) begin
					fin_rseq   = active_q ? cur_seq_q : '0;
					fin_pstate = active_q ? tbpd_pkg::PS_PROGRESS : tbpd_pkg::PS_IDLE;
				end else if (cur_match) begin
					fin_pstate = tbpd_pkg::PS_PROGRESS;
				end else if (ring_hit) begin
					fin_pstate = ring_hit_res;
				end else begin
					fin_pstate = tbpd_pkg::PS_NOT_FOUND;
				end
			end
			tbpd_pkg::OP_RELEASE: begin
				fin_held = neutral_q;
				if (active_q) begin
					fin_end        = 1'b1;
					fin_active     = 1'b0;
					fin_settling   = 1'b0;
					fin_settle_len = '0;
					fin_cd         = '0;
					fin_cur        = '0;
				end
			end
			tbpd_pkg::OP_TICK: begin
				fin_held = held_q;
			end
		endcase
	end

	// Advance the pulse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			settling_q   <= 1'b0;
			inj_q        <= 1'b0;
			cur_seq_q    <= '0;
			held_q       <= tbpd_pkg::NEUTRAL_RST;
			settle_len_q <= '0;
			countdown_q  <= '0;
		end else if (cmd.service) begin
			active_q     <= svc_active;
			settling_q   <= svc_settling;
			cur_seq_q    <= svc_cur;
			held_q       <= svc_held;
			settle_len_q <= svc_settle_len;
			countdown_q  <= svc_cd;
		end else if (cmd.finish) begin
			active_q     <= fin_active;
			settling_q   <= fin_settling;
			inj_q        <= fin_inj;
			cur_seq_q    <= fin_cur;
			held_q       <= fin_held;
			settle_len_q <= fin_settle_len;
			countdown_q  <= fin_cd;
		end
	end

	// Load the result fields
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= fin_status;
			rseq_q   <= fin_rseq;
			pstate_q <= fin_pstate;
		end
	end

	// Record terminal states of ended pulses
	assign ring_we     = (cmd.service && svc_end) || (cmd.finish && fin_end);
	assign ring_wr_res = cmd.service ? svc_st : tbpd_pkg::PS_ABORTED;

	tbpd_ring #(
		.DEPTH(RECENT_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (ring_we),
		.wr_seq   (cur_seq_q),
		.wr_res   (ring_wr_res),
		.scan_clr (cmd.service),
		.scan_step(cmd.scan),
		.key      (seq_q),
		.hit      (ring_hit),
		.hit_res  (ring_hit_res),
		.scan_done(scan_done)
	);

	assign stat.is_tick   = (op_q == tbpd_pkg::OP_TICK);
	assign stat.need_scan = (op_q == tbpd_pkg::OP_PULSE) || (op_q == tbpd_pkg::OP_STATUS);
	assign stat.scan_done = scan_done;

	assign status_code       = status_q;
	assign reported_sequence = rseq_q;
	assign pulse_state       = pstate_q;
	assign driven_buttons    = (active_q && !settling_q) ? held_q : neutral_q;
	assign time_remaining    = active_q ? countdown_q : '0;
	assign hid_enabled       = inj_q;
	assign legacy_flag       = legacy_q;
	assign pulse_busy        = active_q;

endmodule

// ===== hdl/tbpd_ctrl.sv =====
// Controller: per item, capture, service, ring scan if needed, finish and strobe unless a tick.
module tbpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output tbpd_pkg::ctl_cmd_t cmd,
	input  tbpd_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SVC  = 4'b0010,
		S_SCAN = 4'b0100,
		S_FIN  = 4'b1000
	} ctl_state_t;

	ctl_state_t state_q, state_d;
	logic       done_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.service = 1'b0;
		cmd.scan    = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_SVC;
				end
			end
			S_SVC: begin
				cmd.service = 1'b1;
				if (stat.is_tick) begin
					state_d = S_IDLE;
				end else if (stat.need_scan) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state, raise the strobe after finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/timed_button_pulse_dedupe_core.sv =====
// Timed button pulse core with sequence dedupe: top level joining controller and datapath.
// Tick: accepted, serviced in the next cycle, no result; next item accepted once back in idle.
// Release all: strobe follows the service and finish states; next accept in the strobe cycle.
// Pulse and status: result strobe follows the service, ring scan and finish states; the ring
// lookup reads one entry per cycle through its single read port. Results are strobed for
// one cycle and cannot be stalled. Asynchronous active-low reset clears controller, config,
// pulse state and ring valid bits at once, not ring or result data; no clearing pass.
module timed_button_pulse_dedupe_core #(
	parameter int RECENT_DEPTH = tbpd_pkg::RECENT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cfg_we,
	input  logic [tbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tbpd_pkg::OP_W-1:0]       opcode,
	input  logic [tbpd_pkg::SEQ_W-1:0]      sequence_id,
	input  logic [tbpd_pkg::BTN_W-1:0]      buttons,
	input  logic [tbpd_pkg::MS_W-1:0]       hold_ms,
	input  logic [tbpd_pkg::MS_W-1:0]       settle_ms,
	input  logic                            legacy_on,
	input  logic                            enable_failed,
	output logic                            done,
	output logic [tbpd_pkg::CODE_W-1:0]     status_code,
	output logic [tbpd_pkg::SEQ_W-1:0]      reported_sequence,
	output logic [tbpd_pkg::CODE_W-1:0]     pulse_state,
	output logic [tbpd_pkg::BTN_W-1:0]      driven_buttons,
	output logic [tbpd_pkg::MS_W-1:0]       time_remaining,
	output logic                            hid_enabled,
	output logic                            legacy_flag,
	output logic                            pulse_busy
);

	tbpd_pkg::ctl_cmd_t cmd;
	tbpd_pkg::dp_stat_t stat;

	tbpd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.stat  (stat)
	);

	tbpd_datapath #(
		.RECENT_DEPTH(RECENT_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.sequence_id      (sequence_id),
		.buttons          (buttons),
		.hold_ms          (hold_ms),
		.settle_ms        (settle_ms),
		.legacy_on        (legacy_on),
		.enable_failed    (enable_failed),
		.status_code      (status_code),
		.reported_sequence(reported_sequence),
		.pulse_state      (pulse_state),
		.driven_buttons   (driven_buttons),
		.time_remaining   (time_remaining),
		.hid_enabled      (hid_enabled),
		.legacy_flag      (legacy_flag),
		.pulse_busy       (pulse_busy)
	);

endmodule

// ===== hdl/tbpd_checker.sv =====
// Port-level checker for the pulse core and its bind to the top level.
module tbpd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [tbpd_pkg::CODE_W-1:0] status_code,
	input logic [tbpd_pkg::CODE_W-1:0] pulse_state,
	input logic [tbpd_pkg::MS_W-1:0]   time_remaining,
	input logic                        pulse_busy
);

	// Result transfer lands only once the item is through
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// No result in the cycle right after an accept
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe directly after accept");

	// Busy only follows an accepted start
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a start");

	// Idle pulse reports no time left
	a_idle_time: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pulse_busy) |-> (time_remaining == '0))
		else $error("time remaining without an active pulse");

	// Busy rejection only while a pulse runs
	a_busy_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_code == tbpd_pkg::ST_BUSY)) |->
			(pulse_busy && (pulse_state == tbpd_pkg::PS_PROGRESS)))
		else $error("busy status without a running pulse");

endmodule

bind timed_button_pulse_dedupe_core tbpd_checker u_tbpd_checker (.*);
